// File: sv/b64fb_pkg.sv
// Shared types and constants of the base64 frame builder.
`default_nettype none
package b64fb_pkg;

	// Reset values of the configuration registers.
	localparam logic [7:0] START_CHAR_RST   = 8'd35;
	localparam logic [7:0] STOP_CHAR_RST    = 8'd13;
	localparam logic [7:0] OFFSET_CHAR_RST  = 8'd61;
	localparam logic [7:0] ADDRESS_BIAS_RST = 8'd97;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_START_CHAR   = 2'd0;
	localparam logic [1:0] REG_STOP_CHAR    = 2'd1;
	localparam logic [1:0] REG_OFFSET_CHAR  = 2'd2;
	localparam logic [1:0] REG_ADDRESS_BIAS = 2'd3;

	localparam int QUEUE_DEPTH = 2;

	// Character positions within the work of one queue entry.
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_START = 4'd0;
	localparam logic [STEP_W-1:0] STEP_DEST  = 4'd1;
	localparam logic [STEP_W-1:0] STEP_CMD   = 4'd2;
	localparam logic [STEP_W-1:0] STEP_CODE0 = 4'd3;
	localparam logic [STEP_W-1:0] STEP_CODE1 = 4'd4;
	localparam logic [STEP_W-1:0] STEP_CODE2 = 4'd5;
	localparam logic [STEP_W-1:0] STEP_CODE3 = 4'd6;
	localparam logic [STEP_W-1:0] STEP_SUMHI = 4'd7;
	localparam logic [STEP_W-1:0] STEP_SUMLO = 4'd8;
	localparam logic [STEP_W-1:0] STEP_STOP  = 4'd9;

	typedef struct packed {
		logic [7:0] start_char;
		logic [7:0] stop_char;
		logic [7:0] offset_char;
		logic [7:0] address_bias;
	} b64fb_cfg_t;

	// One classified item: which sections of the frame it produces.
	typedef struct packed {
		logic       hdr;
		logic       grp;
		logic       tail;
		logic [7:0] byte_a;
		logic [7:0] byte_b;
		logic [7:0] byte_c;
		logic [7:0] dest;
		logic [7:0] cmd;
	} b64fb_entry_t;

endpackage
`default_nettype wire

// File: sv/base64_frame_builder_sum_checksum.sv
// Base64 frame builder with a 12-bit additive checksum: top level.
// Each item passes the queue, the current-item register and the output register.
// Throughput: one character per cycle while m_tready is high; an item causes
// 0 to 10 characters (4 per byte group), stepped out by the back-end sequencer.
// The input side keeps taking beats while the queue has room.
// Reset: arst_n clears frame state, queue and output; registers return to defaults.
`default_nettype none
module base64_frame_builder_sum_checksum import b64fb_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // data_byte, destination, command
	input  wire logic        s_tuser,   // has_data
	input  wire logic        s_tlast,   // last_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // out_char
	output logic             m_tlast,   // frame_end
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	b64fb_cfg_t   cfg_q;
	b64fb_entry_t push_entry;
	b64fb_entry_t pop_entry;
	logic         q_push;
	logic         q_full;
	logic         q_pop;
	logic         q_nonempty;
	logic         cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_char   <= START_CHAR_RST;
			cfg_q.stop_char    <= STOP_CHAR_RST;
			cfg_q.offset_char  <= OFFSET_CHAR_RST;
			cfg_q.address_bias <= ADDRESS_BIAS_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_START_CHAR:   cfg_q.start_char   <= pwdata[7:0];
				REG_STOP_CHAR:    cfg_q.stop_char    <= pwdata[7:0];
				REG_OFFSET_CHAR:  cfg_q.offset_char  <= pwdata[7:0];
				REG_ADDRESS_BIAS: cfg_q.address_bias <= pwdata[7:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_START_CHAR:   prdata = {24'd0, cfg_q.start_char};
			REG_STOP_CHAR:    prdata = {24'd0, cfg_q.stop_char};
			REG_OFFSET_CHAR:  prdata = {24'd0, cfg_q.offset_char};
			REG_ADDRESS_BIAS: prdata = {24'd0, cfg_q.address_bias};
		endcase
	end

	b64fb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (push_entry)
	);

	b64fb_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.din      (push_entry),
		.full     (q_full),
		.pop      (q_pop),
		.dout     (pop_entry),
		.nonempty (q_nonempty)
	);

	b64fb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_nonempty (q_nonempty),
		.q_entry    (pop_entry),
		.q_pop      (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule
`default_nettype wire

// File: sv/b64fb_front.sv
// Front end: accepts payload beats, groups bytes and classifies each item.
`default_nettype none
module b64fb_front import b64fb_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [23:0]  s_tdata,   // data_byte, destination, command
	input  wire logic         s_tuser,   // has_data
	input  wire logic         s_tlast,   // last_byte
	input  wire logic         q_full,
	output logic              q_push,
	output b64fb_entry_t      q_entry
);

	logic       in_frame_q;
	logic [1:0] fill_q;
	logic [7:0] held0_q;
	logic [7:0] held1_q;

	logic       acc;
	logic [1:0] fill_n;
	logic [7:0] held0_n;
	logic [7:0] held1_n;
	logic       in_frame_n;

	assign s_tready = !q_full;
	assign acc      = s_tvalid && s_tready;

	always_comb begin
		logic [7:0] data;
		data       = s_tdata[7:0];
		q_entry    = '0;
		q_entry.dest = s_tdata[15:8];
		q_entry.cmd  = s_tdata[23:16];
		q_entry.hdr  = !in_frame_q;
		fill_n     = in_frame_q ? fill_q : 2'd0;
		held0_n    = in_frame_q ? held0_q : 8'd0;
		held1_n    = in_frame_q ? held1_q : 8'd0;
		in_frame_n = 1'b1;
		if (s_tuser) begin
			if (fill_n == 2'd2) begin
				q_entry.grp    = 1'b1;
				q_entry.byte_a = held0_n;
				q_entry.byte_b = held1_n;
				q_entry.byte_c = data;
				fill_n         = 2'd0;
			end else begin
				if (fill_n == 2'd0) begin
					held0_n = data;
				end else begin
					held1_n = data;
				end
				fill_n = fill_n + 2'd1;
			end
		end
		if (s_tlast) begin
			// A partial group is padded with zero bytes.
			if (fill_n != 2'd0) begin
				q_entry.grp    = 1'b1;
				q_entry.byte_a = held0_n;
				q_entry.byte_b = (fill_n == 2'd2) ? held1_n : 8'd0;
				q_entry.byte_c = 8'd0;
			end
			q_entry.tail = 1'b1;
			fill_n       = 2'd0;
			held0_n      = 8'd0;
			held1_n      = 8'd0;
			in_frame_n   = 1'b0;
		end
	end

	// Items that produce no character never enter the queue.
	assign q_push = acc && (q_entry.hdr || q_entry.grp || q_entry.tail);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			fill_q     <= 2'd0;
			held0_q    <= 8'd0;
			held1_q    <= 8'd0;
		end else if (acc) begin
			in_frame_q <= in_frame_n;
			fill_q     <= fill_n;
			held0_q    <= held0_n;
			held1_q    <= held1_n;
		end
	end

endmodule
`default_nettype wire

// File: sv/b64fb_queue.sv
// Small FIFO of classified items between the front and back ends.
`default_nettype none
module b64fb_queue import b64fb_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire b64fb_entry_t din,
	output logic              full,
	input  wire logic         pop,
	output b64fb_entry_t      dout,
	output logic              nonempty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	b64fb_entry_t    mem_q [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;

	assign full     = (cnt_q == CW'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign dout     = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: sv/b64fb_back.sv
// Back end: steps through the characters of each item and keeps the checksum.
`default_nettype none
module b64fb_back import b64fb_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire b64fb_cfg_t   cfg,
	input  wire logic         q_nonempty,
	input  wire b64fb_entry_t q_entry,
	output logic              q_pop,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [7:0]        m_tdata,   // out_char
	output logic              m_tlast    // frame_end
);

	b64fb_entry_t      cur_q;
	logic              cur_vld_q;
	logic [STEP_W-1:0] step_q;
	logic [11:0]       sum_q;
	logic              out_vld_q;
	logic [7:0]        out_data_q;
	logic              out_last_q;

	logic              advance;
	logic              done;
	logic [STEP_W-1:0] first_step;
	logic [STEP_W-1:0] next_step;
	logic              next_vld;
	logic [5:0]        code;
	logic [7:0]        ch;

	assign advance = cur_vld_q && (!out_vld_q || m_tready);
	assign done    = advance && !next_vld;
	assign q_pop   = q_nonempty && (!cur_vld_q || done);

	// Entries in the queue always produce at least one character.
	always_comb begin
		if (q_entry.hdr) begin
			first_step = STEP_START;
		end else if (q_entry.grp) begin
			first_step = STEP_CODE0;
		end else begin
			first_step = STEP_SUMHI;
		end
	end

	always_comb begin
		next_step = step_q + 1'b1;
		next_vld  = 1'b1;
		if (step_q == STEP_CMD) begin
			next_step = cur_q.grp ? STEP_CODE0 : STEP_SUMHI;
			next_vld  = cur_q.grp || cur_q.tail;
		end else if (step_q == STEP_CODE3) begin
			next_vld = cur_q.tail;
		end else if (step_q == STEP_STOP) begin
			next_vld = 1'b0;
		end
	end

	always_comb begin
		unique case (step_q)
			STEP_CODE0: code = cur_q.byte_a[7:2];
			STEP_CODE1: code = {cur_q.byte_a[1:0], cur_q.byte_b[7:4]};
			STEP_CODE2: code = {cur_q.byte_b[3:0], cur_q.byte_c[7:6]};
			STEP_SUMHI: code = sum_q[11:6];
			STEP_SUMLO: code = sum_q[5:0];
			default:    code = cur_q.byte_c[5:0];
		endcase
	end

	always_comb begin
		unique case (step_q)
			STEP_START: ch = cfg.start_char;
			STEP_DEST:  ch = cur_q.dest + cfg.address_bias;
			STEP_CMD:   ch = cur_q.cmd;
			STEP_STOP:  ch = cfg.stop_char;
			default:    ch = {2'b00, code} + cfg.offset_char;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_entry;
		end
		if (advance) begin
			out_data_q <= ch;
			out_last_q <= (step_q == STEP_STOP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
			step_q    <= STEP_START;
			sum_q     <= 12'd0;
			out_vld_q <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_vld_q <= 1'b1;
				step_q    <= first_step;
			end else if (done) begin
				cur_vld_q <= 1'b0;
			end else if (advance) begin
				step_q <= next_step;
			end
			// The start character restarts the sum; the checksum and stop
			// characters are not summed.
			if (advance) begin
				if (step_q == STEP_START) begin
					sum_q <= {4'd0, ch};
				end else if (step_q <= STEP_CODE3) begin
					sum_q <= sum_q + {4'd0, ch};
				end
			end
			if (advance) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule
`default_nettype wire

// File: sv/b64fb_checker.sv
// Port-level checker for the frame builder and its bind to the top level.
`default_nettype none
module b64fb_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [7:0]  m_tdata,
	input wire logic        m_tlast,
	input wire logic        psel,
	input wire logic        penable,
	input wire logic        pwrite,
	input wire logic [3:0]  paddr,
	input wire logic [31:0] pwdata,
	input wire logic [31:0] prdata,
	input wire logic        pready
);

	// A stalled output beat holds its character and end mark.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output beat changed while stalled");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

	// A register reads back the byte written to it in the cycle before.
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready)
		##1 (psel && !pwrite && paddr[3:2] == $past(paddr[3:2]))
		|-> prdata == {24'd0, $past(pwdata[7:0])})
		else $error("register readback mismatch");

	// Register reads never show bits above the eight-bit registers.
	a_prdata_upper: assert property (@(posedge clk) disable iff (!arst_n)
		prdata[31:8] == 24'd0)
		else $error("upper read data bits set");

endmodule

bind base64_frame_builder_sum_checksum b64fb_checker u_b64fb_checker (.*);
`default_nettype wire
